// ===== hdl/window_p95_share_gate_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the window P95 share gate
// Shared property forms; clock is clk, reset is arst_n.
// ----------------------------------------------------------------------------
`ifndef WINDOW_P95_SHARE_GATE_CORE_ASSERT_SVH
`define WINDOW_P95_SHARE_GATE_CORE_ASSERT_SVH

// same-cycle implication
`define WPSG_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("wpsg same-cycle check failed");

// next-cycle implication
`define WPSG_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("wpsg next-cycle check failed");

`endif

// ===== hdl/wpsg_pkg.sv =====
// ----------------------------------------------------------------------------
// wpsg_pkg
// Types and constants shared by the share gate controller and datapath.
// ----------------------------------------------------------------------------
package wpsg_pkg;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_BEGIN  = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		DEC_INSUFFICIENT = 2'd0,
		DEC_DIRECT       = 2'd1,
		DEC_ELIGIBLE     = 2'd2,
		DEC_RETAINED     = 2'd3
	} dec_t;

	typedef enum logic [1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_GLES3     = 2'd1,
		CFG_UNPACK    = 2'd2,
		CFG_UNUSED    = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CAND,
		ST_SCAN,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	localparam logic [9:0]  THRESHOLD_RESET = 10'd500;
	localparam logic [9:0]  SHARE_MAX       = 10'd1000;
	localparam logic [41:0] PERMILLE        = 42'd1000;
	localparam logic [3:0]  DIV_LAST        = 4'd9;

	typedef struct packed {
		logic take;
		logic latch_cand;
		logic scan;
		logic mul;
		logic div_init;
		logic div_step;
		logic finish;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic complete;
		logic scan_last;
		logic i_last;
		logic div_last;
	} dp_sts_t;

endpackage

// ===== hdl/wpsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpsg_ctrl
// Sequencer: request intake, selection scan, divide and result hand-off.
// ----------------------------------------------------------------------------
module wpsg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  wpsg_pkg::dp_sts_t sts,
	output wpsg_pkg::dp_cmd_t ctl
);

	wpsg_pkg::state_t state_q, state_nx;
	logic ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wpsg_pkg::ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctl.load_out)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		case (state_q)
			wpsg_pkg::ST_IDLE: begin
				if (in_valid) begin
					ctl.take = 1'b1;
					state_nx = sts.complete ? wpsg_pkg::ST_LOAD : wpsg_pkg::ST_OUT;
				end
			end
			wpsg_pkg::ST_LOAD: state_nx = wpsg_pkg::ST_CAND;
			wpsg_pkg::ST_CAND: begin
				ctl.latch_cand = 1'b1;
				state_nx       = wpsg_pkg::ST_SCAN;
			end
			wpsg_pkg::ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_last)
					state_nx = sts.i_last ? wpsg_pkg::ST_MUL : wpsg_pkg::ST_LOAD;
			end
			wpsg_pkg::ST_MUL: begin
				ctl.mul  = 1'b1;
				state_nx = wpsg_pkg::ST_DINIT;
			end
			wpsg_pkg::ST_DINIT: begin
				ctl.div_init = 1'b1;
				state_nx     = wpsg_pkg::ST_DIV;
			end
			wpsg_pkg::ST_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last)
					state_nx = wpsg_pkg::ST_FIN;
			end
			wpsg_pkg::ST_FIN: begin
				ctl.finish = 1'b1;
				state_nx   = wpsg_pkg::ST_OUT;
			end
			wpsg_pkg::ST_OUT: begin
				if (!ov_q || !out_stall) begin
					ctl.load_out = 1'b1;
					state_nx     = wpsg_pkg::ST_IDLE;
				end
			end
			default: state_nx = wpsg_pkg::ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != wpsg_pkg::ST_IDLE);
	assign out_valid = ov_q;

	`include "window_p95_share_gate_core_assert.svh"

	`WPSG_ASSERT_NOW(a_no_overwrite, ov_q && out_stall, !ctl.load_out)
	`WPSG_ASSERT_NEXT(a_take_leaves_idle, ctl.take, state_q != wpsg_pkg::ST_IDLE)
	`WPSG_ASSERT_NEXT(a_scan_to_mul, (state_q == wpsg_pkg::ST_SCAN) && sts.scan_last && sts.i_last, state_q == wpsg_pkg::ST_MUL)

endmodule

// ===== hdl/wpsg_dp.sv =====
// ----------------------------------------------------------------------------
// wpsg_dp
// Sample windows, rank-count selection, share divider and status registers.
// ----------------------------------------------------------------------------
module wpsg_dp #(
	parameter int unsigned WINDOW_SAMPLES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wpsg_pkg::dp_cmd_t  ctl,
	output wpsg_pkg::dp_sts_t  sts,
	input  logic [1:0]         cmd,
	input  logic               was_presented,
	input  logic               retained_frame,
	input  logic signed [31:0] upload_time,
	input  logic signed [31:0] draw_time,
	input  logic signed [31:0] swap_time,
	input  logic               keep_buffered,
	input  logic signed [33:0] trial_worker_p95,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [9:0]         cfg_data,
	output logic [1:0]         decision,
	output logic               begin_granted,
	output logic               experiment_active,
	output logic               buffered_retained,
	output logic               can_run,
	output logic [5:0]         pending_count,
	output logic [31:0]        evaluated_count,
	output logic [31:0]        upload_swap_p95,
	output logic [32:0]        worker_p95,
	output logic [9:0]         share_permille
);

	localparam int unsigned AW   = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
	localparam int unsigned CW   = $clog2(WINDOW_SAMPLES + 1);
	localparam int unsigned KIDX = (WINDOW_SAMPLES * 95 + 99) / 100 - 1;
	localparam logic [AW-1:0] LAST  = AW'(WINDOW_SAMPLES - 1);
	localparam logic [AW-1:0] KSEL  = AW'(KIDX);
	localparam logic [CW-1:0] FLAST = CW'(WINDOW_SAMPLES - 1);
	localparam logic [32:0]   NADD  = 33'(WINDOW_SAMPLES);

	// windows
	logic [31:0] mem_a [WINDOW_SAMPLES];
	logic [32:0] mem_b [WINDOW_SAMPLES];
	logic [31:0] rd_a_q;
	logic [32:0] rd_b_q;
	logic [AW-1:0] rd_addr;

	// status state
	logic [CW-1:0] fill_q;
	wpsg_pkg::dec_t dec_q;
	logic act_q, ret_q, grant_q;
	logic [31:0] usp_q, eval_q;
	logic [32:0] wkp_q;
	logic [9:0]  share_q, thr_q;
	logic g3_q, ub_q;

	// selection and divide
	logic [AW-1:0] i_q, j_q, cnt_a_q, cnt_b_q, cnt_a_nx, cnt_b_nx;
	logic [31:0] cand_a_q;
	logic [32:0] cand_b_q;
	logic [41:0] num_q;
	logic [9:0]  numlo_q, q_q;
	logic [33:0] rem_q, rem_sh;
	logic [3:0]  dc_q;
	logic        ge, less_a, less_b;

	logic [31:0] up_c, dr_c, sw_c, us_w;
	logic [32:0] us_sum, wk_w, eval_sum;
	logic [33:0] wk_sum;
	logic        smp_ok, grant_ok;
	logic [9:0]  share_nx;

	assign up_c = upload_time[31] ? 32'd0 : upload_time;
	assign dr_c = draw_time[31]   ? 32'd0 : draw_time;
	assign sw_c = swap_time[31]   ? 32'd0 : swap_time;
	assign us_sum = {1'b0, up_c} + {1'b0, sw_c};
	assign us_w   = us_sum[31:0];
	assign wk_sum = {2'b00, up_c} + {2'b00, dr_c} + {2'b00, sw_c};
	assign wk_w   = wk_sum[32:0];

	assign smp_ok = was_presented && !retained_frame && !act_q && !ret_q
		&& (dec_q != wpsg_pkg::DEC_RETAINED);
	assign grant_ok = (dec_q == wpsg_pkg::DEC_ELIGIBLE) && !act_q && !ret_q;

	assign sts.complete  = (cmd == wpsg_pkg::CMD_SAMPLE) && smp_ok && (fill_q == FLAST);
	assign sts.scan_last = (j_q == LAST);
	assign sts.i_last    = (i_q == LAST);
	assign sts.div_last  = (dc_q == wpsg_pkg::DIV_LAST);

	// stable rank: smaller values, then equal values at lower index
	assign less_a   = (rd_a_q < cand_a_q) || ((rd_a_q == cand_a_q) && (j_q < i_q));
	assign less_b   = (rd_b_q < cand_b_q) || ((rd_b_q == cand_b_q) && (j_q < i_q));
	assign cnt_a_nx = cnt_a_q + AW'(less_a);
	assign cnt_b_nx = cnt_b_q + AW'(less_b);

	assign rem_sh = {rem_q[32:0], numlo_q[9]};
	assign ge     = (rem_sh >= {1'b0, wkp_q});

	always_comb begin
		if (wkp_q == 33'd0)
			share_nx = 10'd0;
		else if ({1'b0, usp_q} >= wkp_q)
			share_nx = wpsg_pkg::SHARE_MAX;
		else
			share_nx = q_q;
	end

	assign eval_sum = {1'b0, eval_q} + NADD;

	always_comb begin
		if (ctl.latch_cand)
			rd_addr = '0;
		else if (ctl.scan)
			rd_addr = j_q + AW'(1);
		else
			rd_addr = i_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.take && (cmd == wpsg_pkg::CMD_SAMPLE) && smp_ok) begin
			mem_a[fill_q[AW-1:0]] <= us_w;
			mem_b[fill_q[AW-1:0]] <= wk_w;
		end
		rd_a_q <= mem_a[rd_addr];
		rd_b_q <= mem_b[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.take)
			i_q <= '0;
		if (ctl.latch_cand) begin
			cand_a_q <= rd_a_q;
			cand_b_q <= rd_b_q;
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			j_q      <= '0;
		end
		if (ctl.scan) begin
			cnt_a_q <= cnt_a_nx;
			cnt_b_q <= cnt_b_nx;
			j_q     <= j_q + AW'(1);
			if (j_q == LAST)
				i_q <= i_q + AW'(1);
		end
		if (ctl.mul)
			num_q <= {10'd0, usp_q} * wpsg_pkg::PERMILLE;
		if (ctl.div_init) begin
			rem_q   <= {2'b00, num_q[41:10]};
			numlo_q <= num_q[9:0];
			dc_q    <= '0;
		end
		if (ctl.div_step) begin
			rem_q   <= ge ? (rem_sh - {1'b0, wkp_q}) : rem_sh;
			q_q     <= {q_q[8:0], ge};
			numlo_q <= {numlo_q[8:0], 1'b0};
			dc_q    <= dc_q + 4'd1;
		end
		if (ctl.load_out) begin
			decision          <= dec_q;
			begin_granted     <= grant_q;
			experiment_active <= act_q;
			buffered_retained <= ret_q;
			can_run           <= (dec_q == wpsg_pkg::DEC_ELIGIBLE) && g3_q && ub_q;
			pending_count     <= 6'(fill_q);
			evaluated_count   <= eval_q;
			upload_swap_p95   <= usp_q;
			worker_p95        <= wkp_q;
			share_permille    <= share_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			dec_q   <= wpsg_pkg::DEC_INSUFFICIENT;
			act_q   <= 1'b0;
			ret_q   <= 1'b0;
			grant_q <= 1'b0;
			usp_q   <= '0;
			wkp_q   <= '0;
			share_q <= '0;
			eval_q  <= '0;
			thr_q   <= wpsg_pkg::THRESHOLD_RESET;
			g3_q    <= 1'b0;
			ub_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					wpsg_pkg::CFG_THRESHOLD: thr_q <= cfg_data;
					wpsg_pkg::CFG_GLES3:     g3_q  <= cfg_data[0];
					wpsg_pkg::CFG_UNPACK:    ub_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (ctl.take) begin
				grant_q <= 1'b0;
				case (cmd)
					wpsg_pkg::CMD_SAMPLE: begin
						if (smp_ok)
							fill_q <= fill_q + CW'(1);
					end
					wpsg_pkg::CMD_BEGIN: begin
						if (grant_ok) begin
							act_q   <= 1'b1;
							grant_q <= 1'b1;
						end
					end
					wpsg_pkg::CMD_FINISH: begin
						act_q  <= 1'b0;
						ret_q  <= keep_buffered;
						fill_q <= '0;
						if (!trial_worker_p95[33] && (trial_worker_p95 != 34'sd0))
							wkp_q <= trial_worker_p95[32:0];
						dec_q <= keep_buffered ? wpsg_pkg::DEC_RETAINED : wpsg_pkg::DEC_DIRECT;
					end
					default: begin
						fill_q  <= '0;
						dec_q   <= wpsg_pkg::DEC_INSUFFICIENT;
						act_q   <= 1'b0;
						ret_q   <= 1'b0;
						usp_q   <= '0;
						wkp_q   <= '0;
						share_q <= '0;
						eval_q  <= '0;
					end
				endcase
			end
			if (ctl.scan && (j_q == LAST)) begin
				if (cnt_a_nx == KSEL)
					usp_q <= cand_a_q;
				if (cnt_b_nx == KSEL)
					wkp_q <= cand_b_q;
			end
			if (ctl.finish) begin
				share_q <= share_nx;
				dec_q   <= (share_nx >= thr_q) ? wpsg_pkg::DEC_ELIGIBLE : wpsg_pkg::DEC_DIRECT;
				eval_q  <= eval_sum[32] ? 32'hFFFF_FFFF : eval_sum[31:0];
				fill_q  <= '0;
			end
		end
	end

endmodule

// ===== hdl/window_p95_share_gate_core.sv =====
// ----------------------------------------------------------------------------
// window_p95_share_gate_core
// Frame timing gate: windowed P95 of upload+swap and worker time, share gate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one request per accept: a
//   command with its sample or finish fields. Every request yields exactly
//   one status result on the output channel (out_valid / out_stall).
//   Config channel (cfg_valid / cfg_ready, cfg_ready tied high) writes
//   threshold_permille (index 0), gles3_capable (1), unpack_buffer_capable (2);
//   higher indexes are dropped.
// Sequencing:
//   Ordinary requests: the controller goes from idle to the output state,
//   where the result is registered; no new request is taken until then.
//   Window-completing sample: passes through the rank-count scan over the
//   window RAMs (one compare per cycle per window) and then a 10-step
//   restoring divider before its result is registered.
// Reset: internal status clears, threshold returns to 500; result regs
//   and window RAMs are not cleared (RAM entries are written before reads).
// Stall: the result waits in the output register; the next request is taken
//   meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module window_p95_share_gate_core #(
	parameter int unsigned WINDOW_SAMPLES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic               was_presented,
	input  logic               retained_frame,
	input  logic signed [31:0] upload_time,
	input  logic signed [31:0] draw_time,
	input  logic signed [31:0] swap_time,
	input  logic               keep_buffered,
	input  logic signed [33:0] trial_worker_p95,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         decision,
	output logic               begin_granted,
	output logic               experiment_active,
	output logic               buffered_retained,
	output logic               can_run,
	output logic [5:0]         pending_count,
	output logic [31:0]        evaluated_count,
	output logic [31:0]        upload_swap_p95,
	output logic [32:0]        worker_p95,
	output logic [9:0]         share_permille,
	// config write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [9:0]         cfg_data
);

	wpsg_pkg::dp_cmd_t ctl;
	wpsg_pkg::dp_sts_t sts;

	// config writes land at any time; user must issue them only while idle (block does not enforce)
	assign cfg_ready = 1'b1;

	wpsg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// windows, selection, divider and the result register
	wpsg_dp #(
		.WINDOW_SAMPLES (WINDOW_SAMPLES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.sts               (sts),
		.cmd               (cmd),
		.was_presented     (was_presented),
		.retained_frame    (retained_frame),
		.upload_time       (upload_time),
		.draw_time         (draw_time),
		.swap_time         (swap_time),
		.keep_buffered     (keep_buffered),
		.trial_worker_p95  (trial_worker_p95),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.decision          (decision),
		.begin_granted     (begin_granted),
		.experiment_active (experiment_active),
		.buffered_retained (buffered_retained),
		.can_run           (can_run),
		.pending_count     (pending_count),
		.evaluated_count   (evaluated_count),
		.upload_swap_p95   (upload_swap_p95),
		.worker_p95        (worker_p95),
		.share_permille    (share_permille)
	);

endmodule
